// ----- hw/rtl/ngprsd_pkg.sv -----
// Package with payload types, register indexes and constants for the NGP deposit block.
`default_nettype none
package ngprsd_pkg;
  localparam int unsigned MeshXDefault = 64;
  localparam int unsigned MeshYDefault = 64;
  localparam int unsigned MeshZDefault = 64;
  localparam int unsigned AddrW = 18;
  localparam int unsigned CountW = 32;

  localparam logic [2:0] RegLosX = 3'd0;
  localparam logic [2:0] RegLosY = 3'd1;
  localparam logic [2:0] RegLosZ = 3'd2;
  localparam logic [2:0] RegVelScale = 3'd3;
  localparam logic [2:0] RegBoxX = 3'd4;
  localparam logic [2:0] RegBoxY = 3'd5;
  localparam logic [2:0] RegBoxZ = 3'd6;
  localparam logic [2:0] RegInvCell = 3'd7;

  localparam logic [1:0] StatusOk = 2'd0;
  localparam logic [1:0] StatusOutside = 2'd1;
  localparam logic [1:0] StatusSaturated = 2'd2;

  localparam logic CmdDeposit = 1'b0;
  localparam logic CmdRead = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic [31:0]        pos_x;
    logic [31:0]        pos_y;
    logic [31:0]        pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic [17:0]        read_cell;
  } in_item_t;

  typedef struct packed {
    logic [17:0] cell_addr;
    logic [31:0] cell_count;
    logic [1:0]  status;
  } out_item_t;

  // Request from the geometry pipeline to the count memory.
  typedef struct packed {
    logic              rd;
    logic              upd;
    logic [AddrW-1:0]  addr;
  } mem_req_t;
endpackage
`default_nettype wire

// ----- hw/rtl/ngp_redshift_space_deposit.sv -----
// Top level of the redshift-space nearest-grid-point deposit block.
// Sequence: a deposit transaction passes StDot, StDv, StScale, StDisp, StAxisA, StAxisB,
// StAddr, StRead and StWrite into the result register; a read starts at StAddr.
// Handshake: one transaction at a time; input is taken again in the cycle after the
// result is handed on.
// Reset: rst is synchronous; registers return to reset values, then a clearing pass
// zeroes all MESH_X*MESH_Y*MESH_Z cells of the count memory before input is taken.
`default_nettype none
module ngp_redshift_space_deposit #(
  parameter int unsigned MESH_X = ngprsd_pkg::MeshXDefault,
  parameter int unsigned MESH_Y = ngprsd_pkg::MeshYDefault,
  parameter int unsigned MESH_Z = ngprsd_pkg::MeshZDefault
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  wire ngprsd_pkg::in_item_t in_data,
  output logic                  out_valid,
  input  wire                   out_stall,
  output ngprsd_pkg::out_item_t out_data,
  input  wire                   cfg_valid,
  output logic                  cfg_ready,
  input  wire [2:0]             cfg_index,
  input  wire [31:0]            cfg_data
);
  localparam int unsigned NCells = MESH_X * MESH_Y * MESH_Z;
  localparam int unsigned MemAw = (NCells > 1) ? $clog2(NCells) : 1;

  // Sequencer states.
  localparam logic [3:0] StClear = 4'd0;
  localparam logic [3:0] StIdle = 4'd1;
  localparam logic [3:0] StDot = 4'd2;
  localparam logic [3:0] StDv = 4'd3;
  localparam logic [3:0] StScale = 4'd4;
  localparam logic [3:0] StDisp = 4'd5;
  localparam logic [3:0] StAxisA = 4'd6;
  localparam logic [3:0] StAxisB = 4'd7;
  localparam logic [3:0] StAddr = 4'd8;
  localparam logic [3:0] StRead = 4'd9;
  localparam logic [3:0] StWrite = 4'd10;
  localparam logic [3:0] StOut = 4'd11;

  logic [3:0] state;
  logic [MemAw:0] clr_cnt;

  // Configuration registers.
  logic signed [15:0] los_x, los_y, los_z;
  logic [23:0] vel_scale;
  logic [31:0] box_x, box_y, box_z, inv_cell;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      los_x <= '0; los_y <= '0; los_z <= 16'sd16384;
      vel_scale <= 24'd167772;
      box_x <= 32'd65536000; box_y <= 32'd65536000; box_z <= 32'd65536000;
      inv_cell <= 32'd1073742;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ngprsd_pkg::RegLosX: los_x <= cfg_data[15:0];
        ngprsd_pkg::RegLosY: los_y <= cfg_data[15:0];
        ngprsd_pkg::RegLosZ: los_z <= cfg_data[15:0];
        ngprsd_pkg::RegVelScale: vel_scale <= cfg_data[23:0];
        ngprsd_pkg::RegBoxX: box_x <= cfg_data;
        ngprsd_pkg::RegBoxY: box_y <= cfg_data;
        ngprsd_pkg::RegBoxZ: box_z <= cfg_data;
        ngprsd_pkg::RegInvCell: inv_cell <= cfg_data;
        default: ;
      endcase
    end
  end

  ngprsd_pkg::in_item_t item;
  logic in_acc;
  assign in_stall = (state != StIdle);
  assign in_acc = in_valid && !in_stall;

  // Velocity projection datapath; each product is registered before the next is used.
  // Extreme velocities with a full-scale vector push the displacement to 44 bits.
  logic signed [47:0] px, py, pz;
  logic signed [48:0] dot;
  logic signed [34:0] dv;
  logic signed [58:0] sprod;
  logic signed [42:0] s;
  logic signed [58:0] mx, my, mz;
  logic signed [43:0] dx, dy, dz;

  always_ff @(posedge clk) begin
    if (state == StDot) begin
      px <= item.vel_x * los_x;
      py <= item.vel_y * los_y;
      pz <= item.vel_z * los_z;
    end
    if (state == StDv) begin
      dot <= 49'(px) + 49'(py) + 49'(pz);
    end
    if (state == StScale) begin
      sprod <= 59'(dv) * $signed({35'd0, vel_scale});
    end
    if (state == StDisp) begin
      mx <= 59'(s) * los_x;
      my <= 59'(s) * los_y;
      mz <= 59'(s) * los_z;
    end
  end
  assign dv = 35'(dot >>> 14);
  assign s = 43'(sprod >>> 16);
  assign dx = 44'(mx >>> 14);
  assign dy = 44'(my >>> 14);
  assign dz = 44'(mz >>> 14);

  logic ax_en;
  assign ax_en = (state == StAxisA) || (state == StAxisB);
  logic okx, oky, okz;
  logic [9:0] cx, cy, cz;

  ngprsd_axis #(.MESH(MESH_X)) u_ax (.clk, .en(ax_en), .pos(item.pos_x), .disp(dx),
    .box(box_x), .inv_cell, .ok(okx), .cell_idx(cx));
  ngprsd_axis #(.MESH(MESH_Y)) u_ay (.clk, .en(ax_en), .pos(item.pos_y), .disp(dy),
    .box(box_y), .inv_cell, .ok(oky), .cell_idx(cy));
  ngprsd_axis #(.MESH(MESH_Z)) u_az (.clk, .en(ax_en), .pos(item.pos_z), .disp(dz),
    .box(box_z), .inv_cell, .ok(okz), .cell_idx(cz));

  // Each axis checks its own range after the single mesh reduction.
  logic in_grid;
  assign in_grid = okx && oky && okz;

  ngprsd_pkg::mem_req_t req;
  logic [31:0] flat;
  logic        valid_cell;

  // Count memory with registered read.
  logic [31:0] mem [NCells];
  logic [31:0] rdata;
  logic [MemAw-1:0] waddr;
  logic [31:0] wdata;
  logic        we;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[req.addr[MemAw-1:0]];
  end

  always_ff @(posedge clk) begin
    if (state == StAddr) begin
      if (item.cmd == ngprsd_pkg::CmdRead) begin
        flat <= 32'(item.read_cell);
        valid_cell <= 32'(item.read_cell) < 32'(NCells);
      end else begin
        flat <= 32'(cz) + 32'(MESH_Z) * (32'(cy) + 32'(MESH_Y) * 32'(cx));
        valid_cell <= in_grid;
      end
    end
  end

  always_comb begin
    req.rd = (state == StRead);
    req.upd = (state == StWrite) && valid_cell;
    req.addr = flat[ngprsd_pkg::AddrW-1:0];
  end

  logic [31:0] newc;
  logic        sat;
  always_comb begin
    sat = (rdata == 32'hFFFF_FFFF);
    if (item.cmd == ngprsd_pkg::CmdRead) newc = '0;
    else newc = sat ? rdata : rdata + 32'd1;
    if (state == StClear) begin
      we = 1'b1;
      waddr = clr_cnt[MemAw-1:0];
      wdata = '0;
    end else begin
      we = req.upd;
      waddr = flat[MemAw-1:0];
      wdata = newc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) item <= in_data;
    if (state == StWrite) begin
      if (item.cmd == ngprsd_pkg::CmdRead) begin
        out_data.cell_addr <= item.read_cell;
        out_data.cell_count <= valid_cell ? rdata : '0;
        out_data.status <= valid_cell ? ngprsd_pkg::StatusOk : ngprsd_pkg::StatusOutside;
      end else if (!valid_cell) begin
        out_data.cell_addr <= '0;
        out_data.cell_count <= '0;
        out_data.status <= ngprsd_pkg::StatusOutside;
      end else begin
        out_data.cell_addr <= flat[ngprsd_pkg::AddrW-1:0];
        out_data.cell_count <= newc;
        out_data.status <= sat ? ngprsd_pkg::StatusSaturated : ngprsd_pkg::StatusOk;
      end
    end
  end

  assign out_valid = (state == StOut);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StClear;
      clr_cnt <= '0;
    end else begin
      unique case (state)
        StClear: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == (MemAw+1)'(NCells - 1)) state <= StIdle;
        end
        StIdle: if (in_acc) state <= (in_data.cmd == ngprsd_pkg::CmdRead) ? StAddr : StDot;
        StDot: state <= StDv;
        StDv: state <= StScale;
        StScale: state <= StDisp;
        StDisp: state <= StAxisA;
        StAxisA: state <= StAxisB;
        StAxisB: state <= StAddr;
        StAddr: state <= StRead;
        StRead: state <= StWrite;
        StWrite: state <= StOut;
        StOut: if (!out_stall) state <= StIdle;
        default: state <= StIdle;
      endcase
    end
  end

  logic unused;
  assign unused = req.rd;
endmodule
`default_nettype wire

// ----- hw/rtl/ngprsd_axis.sv -----
// One axis: displaced position, wrap, cell index, mesh reduction, over two register stages.
`default_nettype none
module ngprsd_axis #(
  parameter int unsigned MESH = ngprsd_pkg::MeshXDefault
) (
  input  wire               clk,
  input  wire               en,
  input  wire [31:0]        pos,
  input  wire signed [43:0] disp,
  input  wire [31:0]        box,
  input  wire [31:0]        inv_cell,
  output logic              ok,
  output logic [9:0]        cell_idx
);
  logic signed [44:0] p0;
  logic signed [44:0] p1;
  logic signed [44:0] pw;
  logic [42:0]        up;
  logic               neg;
  logic [54:0]        hi;
  logic [51:0]        lo;
  logic [55:0]        sum;
  logic [35:0]        idx;
  logic [35:0]        idx_r;
  logic               pos_ok;

  always_comb begin
    p0 = $signed({13'd0, pos}) + 45'(disp);
    p1 = p0 + $signed({13'd0, box});
    pw = (p0 < 0) ? p1 : p0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg <= pw < 0;
      up  <= pw[42:0];
    end
  end

  always_comb begin
    hi  = 55'(up[42:20]) * 55'(inv_cell);
    lo  = 52'(up[19:0]) * 52'(inv_cell);
    sum = 56'(hi) + 56'(lo[51:20]);
    idx = sum[55:20];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idx_r  <= idx;
      pos_ok <= ~neg;
    end
  end

  // The index is reduced once; anything still past the mesh is outside the grid.
  logic [35:0] red;
  always_comb begin
    red      = (idx_r >= 36'(MESH)) ? idx_r - 36'(MESH) : idx_r;
    ok       = pos_ok && (red < 36'(MESH));
    cell_idx = red[9:0];
  end
endmodule
`default_nettype wire
